/* hw/rtl/mtep_pkg.sv */
// Shared types, constants and decode functions for the MIDI track event parser.
package mtep_pkg;

	localparam int VLV_MAX_BYTES_DEF = 4;
	localparam int TIME_WIDTH_DEF    = 32;
	localparam int ACC_W             = 28;

	// result kinds
	localparam logic [1:0] CLS_CHAN  = 2'd0;
	localparam logic [1:0] CLS_META  = 2'd1;
	localparam logic [1:0] CLS_SYSEX = 2'd2;
	localparam logic [1:0] CLS_ERR   = 2'd3;

	localparam logic [7:0] ST_META    = 8'hFF;
	localparam logic [7:0] META_SEQ   = 8'h00;
	localparam logic [7:0] META_CHPFX = 8'h20;
	localparam logic [7:0] META_EOT   = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] META_SMPTE = 8'h54;
	localparam logic [7:0] META_TSIG  = 8'h58;
	localparam logic [7:0] META_KSIG  = 8'h59;

	localparam logic [3:0] HDR_BYTES = 4'd14;

	typedef struct packed {
		logic clear;     // start a new variable-length value
		logic feed;      // shift in one 7-bit group
		logic add_time;  // add finished delta into absolute time
	} vlv_ctl_t;

	typedef struct packed {
		logic [1:0]       cls;
		logic [7:0]       status;
		logic [7:0]       meta;
		logic [3:0]       chan;
		logic [ACC_W-1:0] v1;
		logic [7:0]       v2;
		logic [7:0]       v3;
		logic [7:0]       v4;
		logic [7:0]       v5;
		logic [31:0]      ev_time;
		logic             last;
	} result_t;

	// expected chunk id bytes, "MTrk"
	function automatic logic [7:0] trk_id_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h4D;
			2'd1: r = 8'h54;
			2'd2: r = 8'h72;
			default: r = 8'h6B;
		endcase
		return r;
	endfunction

	// data bytes after a channel status
	function automatic logic [1:0] chan_len(input logic [7:0] st);
		logic [1:0] r;
		if (st[7:4] == 4'hC || st[7:4] == 4'hD) r = 2'd1;
		else if (st[7]) r = 2'd2;
		else r = 2'd0;
		return r;
	endfunction

	// fixed data count of a meta type; fixed=0 means length-prefixed
	function automatic logic [3:0] meta_len(input logic [7:0] t);
		logic [3:0] r; // {fixed, count}
		case (t)
			META_SEQ:   r = {1'b1, 3'd2};
			META_CHPFX: r = {1'b1, 3'd1};
			META_TEMPO: r = {1'b1, 3'd3};
			META_SMPTE: r = {1'b1, 3'd5};
			META_TSIG:  r = {1'b1, 3'd4};
			META_KSIG:  r = {1'b1, 3'd2};
			META_EOT:   r = {1'b1, 3'd0};
			default:    r = {1'b0, 3'd0};
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/midi_track_event_parser_top.sv */
// Top level of the MIDI track event parser: byte sequencer and result register.
//
// Usage:
// - s_axis carries the Standard MIDI File one byte per request, in file order.
// - The 14-byte header is dropped, then target_track chunks are skipped whole,
//   then the next chunk must be an MTrk chunk; its events are decoded.
// - m_axis gives one request per finished event: tuser is the event class,
//   tlast marks end of track or a bad chunk id. After either, input bytes are
//   still taken but ignored until reset.
// - target_track is loaded by cfg_we / cfg_wdata while the stream is idle.
// Throughput and latency:
// - One byte per cycle. Each byte updates the sequencer state in the cycle it
//   is taken; a result it completes is on m_axis the next cycle.
// - The single output register sets the rate: s_axis_tready is low only while
//   a result is held and m_axis_tready is low. A byte arriving with the held
//   result drained in the same cycle is still taken.
// Reset (arst_n low): sequencer back to header skip, time zero, no result
// pending, target_track zero.
module midi_track_event_parser_top import mtep_pkg::*; #(
	parameter int VLV_MAX_BYTES = VLV_MAX_BYTES_DEF,
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,       // target_track
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,    // [7:0] data_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] status_byte, [15:8] meta_type, [19:16] channel, [47:20] value_one,
	// [55:48] value_two, [63:56] value_three, [71:64] value_four,
	// [79:72] value_five, [111:80] event_time
	output logic [111:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,    // [1:0] event_class
	output logic         m_axis_tlast
);

	localparam logic [3:0] PH_HDR        = 4'd0;
	localparam logic [3:0] PH_SKIP_ID    = 4'd1;
	localparam logic [3:0] PH_SKIP_LEN   = 4'd2;
	localparam logic [3:0] PH_SKIP_BODY  = 4'd3;
	localparam logic [3:0] PH_ID         = 4'd4;
	localparam logic [3:0] PH_LEN        = 4'd5;
	localparam logic [3:0] PH_DELTA      = 4'd6;
	localparam logic [3:0] PH_STATUS     = 4'd7;
	localparam logic [3:0] PH_CHAN_DATA  = 4'd8;
	localparam logic [3:0] PH_META_TYPE  = 4'd9;
	localparam logic [3:0] PH_META_SIZE  = 4'd10;
	localparam logic [3:0] PH_META_FIXED = 4'd11;
	localparam logic [3:0] PH_META_VLV   = 4'd12;
	localparam logic [3:0] PH_SYSEX_LEN  = 4'd13;
	localparam logic [3:0] PH_SKIP_DATA  = 4'd14;
	localparam logic [3:0] PH_HALT       = 4'd15;

	// registered state
	logic [15:0] target_q;
	logic [3:0]  phase_q;
	logic [3:0]  bcnt_q;
	logic [31:0] skip_q;
	logic [15:0] trk_q;
	logic [7:0]  held_st_q;
	logic [7:0]  held_meta_q;
	logic [7:0]  fld_q [5];
	logic        id_ok_q;

	// next state
	logic [3:0]  phase_d;
	logic [3:0]  bcnt_d;
	logic [31:0] skip_d;
	logic [15:0] trk_d;
	logic [7:0]  held_st_d;
	logic [7:0]  held_meta_d;
	logic [7:0]  fld_d [5];
	logic        id_ok_d;

	// helpers
	logic             accept;
	logic [7:0]       b;
	logic [3:0]       bcnt_inc;
	logic [15:0]      trk_inc;
	logic [31:0]      skip_dec;
	logic [31:0]      skip_shift;
	logic [7:0]       fw [5];   // field bytes with this byte written in
	logic [3:0]       mlen;
	logic [3:0]       mlen_in;  // meta decode of the incoming byte
	logic [1:0]       clen;
	logic             emit;
	result_t          res;
	vlv_ctl_t         vctl;
	logic             vlv_done;
	logic [ACC_W-1:0] acc_cur;
	logic [ACC_W-1:0] acc_nxt;
	logic [31:0]      ev_time;

	// output register
	logic    m_valid_q;
	result_t res_q;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign b             = s_axis_tdata;

	assign bcnt_inc   = bcnt_q + 4'd1;
	assign trk_inc    = trk_q + 16'd1;
	assign skip_dec   = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
	assign skip_shift = {skip_q[23:0], b};
	assign mlen       = meta_len(held_meta_q);
	assign mlen_in    = meta_len(b);
	assign clen       = chan_len(held_st_q);

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			fw[i] = (bcnt_q == 4'(i)) ? b : fld_q[i];
		end
	end

	mtep_time #(
		.VLV_MAX_BYTES (VLV_MAX_BYTES),
		.TIME_WIDTH    (TIME_WIDTH)
	) u_time (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (vctl),
		.data_byte  (b),
		.done       (vlv_done),
		.acc_cur    (acc_cur),
		.acc_nxt    (acc_nxt),
		.event_time (ev_time)
	);

	always_comb begin
		phase_d     = phase_q;
		bcnt_d      = bcnt_q;
		skip_d      = skip_q;
		trk_d       = trk_q;
		held_st_d   = held_st_q;
		held_meta_d = held_meta_q;
		fld_d       = fld_q;
		id_ok_d     = id_ok_q;
		emit        = 1'b0;
		res         = '0;
		vctl        = '0;

		case (phase_q)
			PH_HDR: begin
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= HDR_BYTES) begin
					bcnt_d  = '0;
					phase_d = (trk_q < target_q) ? PH_SKIP_ID : PH_ID;
				end
			end
			PH_SKIP_ID: begin
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= 4'd4) begin
					bcnt_d  = '0;
					skip_d  = '0;
					phase_d = PH_SKIP_LEN;
				end
			end
			PH_SKIP_LEN: begin
				skip_d = skip_shift;
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= 4'd4) begin
					bcnt_d = '0;
					if (skip_shift == 32'd0) begin
						trk_d   = trk_inc;
						phase_d = (trk_inc < target_q) ? PH_SKIP_ID : PH_ID;
					end else begin
						phase_d = PH_SKIP_BODY;
					end
				end
			end
			PH_SKIP_BODY: begin
				skip_d = skip_dec;
				if (skip_dec == 32'd0) begin
					trk_d   = trk_inc;
					bcnt_d  = '0;
					phase_d = (trk_inc < target_q) ? PH_SKIP_ID : PH_ID;
				end
			end
			PH_ID: begin
				if (b != trk_id_byte(bcnt_q[1:0])) id_ok_d = 1'b0;
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= 4'd4) begin
					bcnt_d = '0;
					if (!id_ok_d) begin
						emit     = 1'b1;
						res.cls  = CLS_ERR;
						res.last = 1'b1;
						phase_d  = PH_HALT;
					end else begin
						phase_d = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= 4'd4) begin
					bcnt_d     = '0;
					vctl.clear = 1'b1;
					phase_d    = PH_DELTA;
				end
			end
			PH_DELTA: begin
				vctl.feed = 1'b1;
				if (vlv_done) begin
					vctl.add_time = 1'b1;
					phase_d       = PH_STATUS;
				end
			end
			PH_STATUS: begin
				held_st_d   = b;
				held_meta_d = '0;
				for (int i = 0; i < 5; i++) fld_d[i] = '0;
				bcnt_d = '0;
				if (b == ST_META) begin
					phase_d = PH_META_TYPE;
				end else if (b[7:4] == 4'hF) begin
					phase_d = PH_SYSEX_LEN;
				end else if (chan_len(b) == 2'd0) begin
					// data byte in the status slot: event with no data
					emit        = 1'b1;
					res.cls     = CLS_CHAN;
					res.status  = b;
					res.chan    = b[3:0];
					res.ev_time = ev_time;
					vctl.clear  = 1'b1;
					phase_d     = PH_DELTA;
				end else begin
					phase_d = PH_CHAN_DATA;
				end
			end
			PH_CHAN_DATA: begin
				fld_d  = fw;
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= {2'b00, clen}) begin
					emit        = 1'b1;
					res.cls     = CLS_CHAN;
					res.status  = held_st_q;
					res.chan    = held_st_q[3:0];
					res.v1      = ACC_W'(fw[0]);
					res.v2      = fw[1];
					res.ev_time = ev_time;
					vctl.clear  = 1'b1;
					phase_d     = PH_DELTA;
				end
			end
			PH_META_TYPE: begin
				held_meta_d = b;
				if (!mlen_in[3]) begin
					vctl.clear = 1'b1;
					phase_d    = PH_META_VLV;
				end else begin
					phase_d = PH_META_SIZE;
				end
			end
			PH_META_SIZE: begin
				// length byte of a fixed meta is not checked
				if (held_meta_q == META_EOT) begin
					emit        = 1'b1;
					res.cls     = CLS_META;
					res.status  = ST_META;
					res.meta    = META_EOT;
					res.ev_time = ev_time;
					res.last    = 1'b1;
					phase_d     = PH_HALT;
				end else begin
					bcnt_d  = '0;
					phase_d = PH_META_FIXED;
				end
			end
			PH_META_FIXED: begin
				fld_d  = fw;
				bcnt_d = bcnt_inc;
				if (bcnt_inc >= {1'b0, mlen[2:0]}) begin
					emit        = 1'b1;
					res.cls     = CLS_META;
					res.status  = ST_META;
					res.meta    = held_meta_q;
					res.ev_time = ev_time;
					case (held_meta_q)
						META_SEQ:   res.v1 = ACC_W'({fw[0], fw[1]});
						META_CHPFX: res.v1 = ACC_W'(fw[0]);
						META_TEMPO: res.v1 = ACC_W'({fw[0], fw[1], fw[2]});
						META_SMPTE: begin
							res.v1 = ACC_W'(fw[0]);
							res.v2 = fw[1];
							res.v3 = fw[2];
							res.v4 = fw[3];
							res.v5 = fw[4];
						end
						META_TSIG: begin
							res.v1 = ACC_W'(fw[0]);
							res.v2 = fw[1];
							res.v3 = fw[2];
							res.v4 = fw[3];
						end
						META_KSIG: begin
							// key is a signed count of sharps or flats
							res.v1 = {{(ACC_W - 8){fw[0][7]}}, fw[0]} + ACC_W'(7);
							res.v2 = fw[1];
						end
						default: res.v1 = '0;
					endcase
					vctl.clear = 1'b1;
					phase_d    = PH_DELTA;
				end
			end
			PH_META_VLV: begin
				vctl.feed = 1'b1;
				if (vlv_done) begin
					skip_d = 32'(acc_nxt);
					if (acc_nxt == '0) begin
						emit        = 1'b1;
						res.cls     = CLS_META;
						res.status  = ST_META;
						res.meta    = held_meta_q;
						res.v1      = acc_nxt;
						res.ev_time = ev_time;
						vctl.clear  = 1'b1;
						phase_d     = PH_DELTA;
					end else begin
						phase_d = PH_SKIP_DATA;
					end
				end
			end
			PH_SYSEX_LEN: begin
				skip_d = 32'(b);
				if (b == 8'd0) begin
					emit        = 1'b1;
					res.cls     = CLS_SYSEX;
					res.status  = held_st_q;
					res.ev_time = ev_time;
					vctl.clear  = 1'b1;
					phase_d     = PH_DELTA;
				end else begin
					phase_d = PH_SKIP_DATA;
				end
			end
			PH_SKIP_DATA: begin
				skip_d = skip_dec;
				if (skip_dec == 32'd0) begin
					emit        = 1'b1;
					res.ev_time = ev_time;
					if (held_st_q == ST_META) begin
						res.cls    = CLS_META;
						res.status = ST_META;
						res.meta   = held_meta_q;
						res.v1     = acc_cur;
					end else begin
						res.cls    = CLS_SYSEX;
						res.status = held_st_q;
					end
					vctl.clear = 1'b1;
					phase_d    = PH_DELTA;
				end
			end
			default: begin
				// halted: bytes are consumed and dropped
			end
		endcase

		if (!accept) begin
			vctl = '0;
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			phase_q     <= PH_HDR;
			bcnt_q      <= '0;
			skip_q      <= '0;
			trk_q       <= '0;
			held_st_q   <= '0;
			held_meta_q <= '0;
			for (int i = 0; i < 5; i++) fld_q[i] <= '0;
			id_ok_q     <= 1'b1;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) target_q <= cfg_wdata;
			if (accept) begin
				phase_q     <= phase_d;
				bcnt_q      <= bcnt_d;
				skip_q      <= skip_d;
				trk_q       <= trk_d;
				held_st_q   <= held_st_d;
				held_meta_q <= held_meta_d;
				fld_q       <= fld_d;
				id_ok_q     <= id_ok_d;
			end
			if (emit) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) res_q <= res;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_q.cls;
	assign m_axis_tlast  = res_q.last;
	assign m_axis_tdata  = {res_q.ev_time, res_q.v5, res_q.v4, res_q.v3, res_q.v2,
		res_q.v1, res_q.chan, res_q.meta, res_q.status};

	// once halted, the sequencer stays halted
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT) |=> (phase_q == PH_HALT))
		else $error("left halt state without reset");

	// nothing follows the final request
	a_no_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("result after end of track");

	// id error carries last and an empty payload
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == CLS_ERR)) |->
		(m_axis_tlast && (m_axis_tdata == '0)))
		else $error("malformed chunk id error result");

	// last only on end of track or id error
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		((m_axis_tuser == CLS_ERR) ||
		 ((m_axis_tuser == CLS_META) && (m_axis_tdata[15:8] == META_EOT))))
		else $error("last on an ordinary event");

endmodule

/* hw/rtl/mtep_time.sv */
// Variable-length value accumulator and saturating absolute tick time.
module mtep_time import mtep_pkg::*; #(
	parameter int VLV_MAX_BYTES = VLV_MAX_BYTES_DEF,
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vlv_ctl_t         ctl,
	input  logic [7:0]       data_byte,
	output logic             done,       // this byte ends the value
	output logic [ACC_W-1:0] acc_cur,
	output logic [ACC_W-1:0] acc_nxt,    // value including this byte
	output logic [31:0]      event_time
);

	localparam int CNT_W = $clog2(VLV_MAX_BYTES + 1);
	localparam int SW    = ((TIME_WIDTH > ACC_W) ? TIME_WIDTH : ACC_W) + 1;
	localparam int EW    = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	logic [ACC_W-1:0]      acc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_WIDTH-1:0] abs_q;
	logic [SW-1:0]         sum;
	logic [SW-1:0]         tmax_ext;
	logic [TIME_WIDTH-1:0] abs_d;
	logic [EW-1:0]         time_ext;

	assign acc_cur  = acc_q;
	assign acc_nxt  = {acc_q[ACC_W-8:0], data_byte[6:0]};
	assign done     = !data_byte[7] ||
		(({1'b0, cnt_q} + 1'b1) >= (CNT_W + 1)'(VLV_MAX_BYTES));

	assign tmax_ext = SW'({TIME_WIDTH{1'b1}});
	assign sum      = SW'(abs_q) + SW'(acc_nxt);
	assign abs_d    = (sum > tmax_ext) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

	assign time_ext   = EW'(abs_q);
	assign event_time = time_ext[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			abs_q <= '0;
		end else begin
			if (ctl.clear) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else if (ctl.feed) begin
				acc_q <= acc_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctl.add_time) begin
				abs_q <= abs_d;
			end
		end
	end

	// value is cut at VLV_MAX_BYTES groups, so the count never passes it
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} <= (CNT_W + 1)'(VLV_MAX_BYTES)))
		else $error("vlv group count beyond limit");

	// time only moves on a finished delta
	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.add_time |=> $stable(abs_q))
		else $error("absolute time changed without a delta");

	// time is monotonic
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.add_time |=> (abs_q >= $past(abs_q)))
		else $error("absolute time went backward");

endmodule

/* test/tb_midi_track_event_parser_top.sv */
// Self-checking testbench for the MIDI track event parser: byte stream in, event requests out.
`timescale 1ns / 1ps

module tb_midi_track_event_parser_top;
	import mtep_pkg::*;

	// Track parsing phases of the expected-event tracker; the block hides its own.
	typedef enum {
		P_HEADER, P_SKIP_ID, P_SKIP_LEN, P_SKIP_BODY, P_TRK_ID, P_TRK_LEN,
		P_DELTA, P_STATUS, P_CHAN_DATA, P_META_TYPE, P_META_SIZE, P_META_FIXED,
		P_META_LEN, P_SYSEX_LEN, P_SKIP_DATA, P_HALTED
	} track_phase_t;

	localparam int          VLV_CAP   = VLV_MAX_BYTES_DEF;
	localparam logic [31:0] TRACK_TAG = "MTrk";
	localparam int          IDLE_PCT  = 34;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// [7:0] status_byte, [15:8] meta_type, [19:16] channel, [47:20] value_one,
	// [55:48] value_two, [63:56] value_three, [71:64] value_four,
	// [79:72] value_five, [111:80] event_time
	logic [111:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;        // [1:0] event_class
	logic         m_axis_tlast;

	midi_track_event_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Events the parser owes us, oldest first.
	result_t pending_events[$];
	int      mismatches = 0;
	int      bytes_sent = 0;
	int      idle_pct = IDLE_PCT;   // shared by sender and receiver; 0 = back-to-back

	// Tracker copy of the parser state and of target_track.
	track_phase_t ph = P_HEADER;
	int           cnt = 0;
	logic [31:0]  skip_left = '0;
	logic [15:0]  skipped = '0;
	logic [15:0]  target = '0;
	logic [27:0]  acc = '0;
	int           acc_bytes = 0;
	logic [31:0]  tick = '0;
	logic [7:0]   st_held = '0;
	logic [7:0]   meta_held = '0;
	logic [7:0]   fb [5] = '{default: 8'h00};
	logic         id_good = 1'b1;

	// ---------------------------------------------------------------
	// Event tracker
	// ---------------------------------------------------------------

	// data bytes that follow a channel status
	function automatic int data_count(input logic [7:0] st);
		if (st[7:4] == 4'hC || st[7:4] == 4'hD) return 1;
		if (st[7]) return 2;
		return 0;
	endfunction

	// payload size of a fixed meta type, -1 when a length value follows instead
	function automatic int fixed_count(input logic [7:0] ty);
		case (ty)
			META_SEQ, META_KSIG: return 2;
			META_CHPFX:          return 1;
			META_TEMPO:          return 3;
			META_SMPTE:          return 5;
			META_TSIG:           return 4;
			META_EOT:            return 0;
			default:             return -1;
		endcase
	endfunction

	// after the header and after each skipped chunk: skip another or parse this one
	function automatic void open_chunk();
		cnt = 0;
		ph = (skipped < target) ? P_SKIP_ID : P_TRK_ID;
	endfunction

	function automatic void begin_delta();
		acc = '0;
		acc_bytes = 0;
		ph = P_DELTA;
	endfunction

	// shift in one 7-bit group; true when the value is complete
	function automatic logic take_group(input logic [7:0] b);
		acc = {acc[20:0], b[6:0]};
		acc_bytes++;
		return !b[7] || acc_bytes >= VLV_CAP;
	endfunction

	// append an owed event behind the ones already waiting
	function automatic void queue_event(input result_t r);
		pending_events.insert(pending_events.size(), r);
	endfunction

	function automatic void owe_channel();
		result_t r;
		r = '0;
		r.cls = CLS_CHAN;
		r.status = st_held;
		r.chan = st_held[3:0];
		r.v1 = 28'(fb[0]);
		r.v2 = fb[1];
		r.ev_time = tick;
		queue_event(r);
	endfunction

	// sysex, or a length-prefixed meta whose payload has been skipped
	function automatic void owe_skipped();
		result_t r;
		r = '0;
		r.ev_time = tick;
		if (st_held == ST_META) begin
			r.cls = CLS_META;
			r.status = ST_META;
			r.meta = meta_held;
			r.v1 = acc;
		end else begin
			r.cls = CLS_SYSEX;
			r.status = st_held;
		end
		queue_event(r);
	endfunction

	function automatic void owe_fixed_meta();
		result_t r;
		r = '0;
		r.cls = CLS_META;
		r.status = ST_META;
		r.meta = meta_held;
		r.ev_time = tick;
		case (meta_held)
			META_SEQ:   r.v1 = 28'({fb[0], fb[1]});
			META_CHPFX: r.v1 = 28'(fb[0]);
			META_TEMPO: r.v1 = 28'({fb[0], fb[1], fb[2]});
			META_SMPTE: begin
				r.v1 = 28'(fb[0]);
				r.v2 = fb[1];
				r.v3 = fb[2];
				r.v4 = fb[3];
				r.v5 = fb[4];
			end
			META_TSIG: begin
				r.v1 = 28'(fb[0]);
				r.v2 = fb[1];
				r.v3 = fb[2];
				r.v4 = fb[3];
			end
			META_KSIG: begin
				// key is a signed count of sharps/flats, offset by seven, wraps in 28 bits
				r.v1 = {{20{fb[0][7]}}, fb[0]} + 28'd7;
				r.v2 = fb[1];
			end
			default: ;
		endcase
		queue_event(r);
	endfunction

	// Advance the tracker by one accepted byte, queueing any finished event.
	function automatic void parse_byte(input logic [7:0] b);
		result_t     r;
		logic [32:0] sum;
		case (ph)
			P_HEADER: begin
				cnt++;
				if (cnt >= HDR_BYTES) open_chunk();
			end
			P_SKIP_ID: begin
				cnt++;
				if (cnt >= 4) begin
					cnt = 0;
					skip_left = '0;
					ph = P_SKIP_LEN;
				end
			end
			P_SKIP_LEN: begin
				skip_left = {skip_left[23:0], b};
				cnt++;
				if (cnt >= 4) begin
					cnt = 0;
					if (skip_left == 0) begin
						skipped++;
						open_chunk();
					end else ph = P_SKIP_BODY;
				end
			end
			P_SKIP_BODY: begin
				if (skip_left != 0) skip_left--;
				if (skip_left == 0) begin
					skipped++;
					open_chunk();
				end
			end
			P_TRK_ID: begin
				if (b != TRACK_TAG[8 * (3 - cnt) +: 8]) id_good = 1'b0;
				cnt++;
				if (cnt >= 4) begin
					cnt = 0;
					if (!id_good) begin
						r = '0;
						r.cls = CLS_ERR;
						r.last = 1'b1;
						queue_event(r);
						ph = P_HALTED;
					end else ph = P_TRK_LEN;
				end
			end
			P_TRK_LEN: begin
				cnt++;
				if (cnt >= 4) begin
					cnt = 0;
					begin_delta();
				end
			end
			P_DELTA: begin
				if (take_group(b)) begin
					// absolute time sticks at all ones
					sum = {1'b0, tick} + 33'(acc);
					tick = sum[32] ? '1 : sum[31:0];
					ph = P_STATUS;
				end
			end
			P_STATUS: begin
				st_held = b;
				meta_held = '0;
				foreach (fb[i]) fb[i] = '0;
				cnt = 0;
				if (b == ST_META) ph = P_META_TYPE;
				else if (b[7:4] == 4'hF) ph = P_SYSEX_LEN;
				else if (data_count(b) == 0) begin
					owe_channel();
					begin_delta();
				end else ph = P_CHAN_DATA;
			end
			P_CHAN_DATA: begin
				if (cnt < 5) fb[cnt] = b;
				cnt++;
				if (cnt >= data_count(st_held)) begin
					owe_channel();
					begin_delta();
				end
			end
			P_META_TYPE: begin
				meta_held = b;
				if (fixed_count(b) < 0) begin
					acc = '0;
					acc_bytes = 0;
					ph = P_META_LEN;
				end else ph = P_META_SIZE;
			end
			P_META_SIZE: begin
				// length byte of a fixed type is not looked at
				if (meta_held == META_EOT) begin
					r = '0;
					r.cls = CLS_META;
					r.status = ST_META;
					r.meta = META_EOT;
					r.ev_time = tick;
					r.last = 1'b1;
					queue_event(r);
					ph = P_HALTED;
				end else begin
					cnt = 0;
					ph = P_META_FIXED;
				end
			end
			P_META_FIXED: begin
				if (cnt < 5) fb[cnt] = b;
				cnt++;
				if (cnt >= fixed_count(meta_held)) begin
					owe_fixed_meta();
					begin_delta();
				end
			end
			P_META_LEN: begin
				if (take_group(b)) begin
					skip_left = 32'(acc);
					if (skip_left == 0) begin
						owe_skipped();
						begin_delta();
					end else ph = P_SKIP_DATA;
				end
			end
			P_SYSEX_LEN: begin
				skip_left = 32'(b);
				if (skip_left == 0) begin
					owe_skipped();
					begin_delta();
				end else ph = P_SKIP_DATA;
			end
			P_SKIP_DATA: begin
				if (skip_left != 0) skip_left--;
				if (skip_left == 0) begin
					owe_skipped();
					begin_delta();
				end
			end
			default: ;  // halted: bytes are swallowed
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Receiver side: random back-pressure, result check at the rising edge
	// ---------------------------------------------------------------

	always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);

	function automatic void check_field(input string fname, input logic [31:0] want, got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event request: class %0d status 0x%0h",
					m_axis_tuser, m_axis_tdata[7:0]);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_class", 32'(want.cls), 32'(m_axis_tuser));
				check_field("status_byte", 32'(want.status), 32'(m_axis_tdata[7:0]));
				check_field("meta_type", 32'(want.meta), 32'(m_axis_tdata[15:8]));
				check_field("channel", 32'(want.chan), 32'(m_axis_tdata[19:16]));
				check_field("value_one", 32'(want.v1), 32'(m_axis_tdata[47:20]));
				check_field("value_two", 32'(want.v2), 32'(m_axis_tdata[55:48]));
				check_field("value_three", 32'(want.v3), 32'(m_axis_tdata[63:56]));
				check_field("value_four", 32'(want.v4), 32'(m_axis_tdata[71:64]));
				check_field("value_five", 32'(want.v5), 32'(m_axis_tdata[79:72]));
				check_field("event_time", want.ev_time, m_axis_tdata[111:80]);
				check_field("last", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender side
	// ---------------------------------------------------------------

	// One byte request. Returns right after the accepting edge with tvalid
	// still high, so the next call can follow without a bubble; settle()
	// drops tvalid when the stream has to pause.
	task automatic push_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		parse_byte(b);
		bytes_sent++;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stop sending and wait for every owed event; the extra wait after that lets a
	// byte that finished no event be surely absorbed.
	task automatic settle(input int extra);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// only called with the stream idle
	task automatic write_target(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		target = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// variable-length value, padded with empty leading groups up to min_groups
	task automatic put_vlv(input logic [27:0] v, input int min_groups);
		int n;
		n = (v >= 28'h200000) ? 4 : (v >= 28'h4000) ? 3 : (v >= 28'h80) ? 2 : 1;
		if (min_groups > n) n = min_groups;
		for (int i = n - 1; i >= 0; i--) push_byte({i != 0, 7'(v >> (7 * i))});
	endtask

	task automatic skip_chunk(input logic [31:0] len);
		repeat (4) push_byte(8'($urandom_range(0, 255)));
		for (int i = 3; i >= 0; i--) push_byte(len[8 * i +: 8]);
		repeat (len) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic chan_body(input logic [7:0] st, input logic [7:0] d1, d2);
		push_byte(st);
		if (data_count(st) > 0) push_byte(d1);
		if (data_count(st) > 1) push_byte(d2);
	endtask

	task automatic sysex_body(input logic [7:0] st, input logic [7:0] len);
		push_byte(st);
		push_byte(len);
		repeat (len) push_byte(8'($urandom_range(0, 255)));
	endtask

	// payload goes out from its top byte down
	task automatic meta_fixed_body(input logic [7:0] ty, input logic [39:0] payload);
		push_byte(ST_META);
		push_byte(ty);
		push_byte(8'($urandom_range(0, 255)));
		for (int i = 0; i < fixed_count(ty); i++) push_byte(payload[39 - 8 * i -: 8]);
	endtask

	task automatic meta_text_body(input logic [7:0] ty, input logic [27:0] len,
			input int min_groups);
		push_byte(ST_META);
		push_byte(ty);
		put_vlv(len, min_groups);
		repeat (len) push_byte(8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Header, chunk skipping under changing target_track, then the MTrk chunk.
	task automatic test_track_select();
		write_target(16'h0000);
		write_target(16'hFFFF);
		repeat (14) push_byte(8'($urandom_range(0, 255)));
		skip_chunk(32'd0);
		skip_chunk(32'($urandom_range(1, 40)));
		settle(4);
		// lower the target on the fly: parsing starts after the fourth chunk
		write_target(16'd4);
		skip_chunk(32'd259);
		skip_chunk(32'd0);
		for (int i = 0; i < 4; i++) push_byte(TRACK_TAG[8 * (3 - i) +: 8]);
		repeat (4) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_channel_events();
		put_vlv(28'd0, 0);       chan_body(8'h90, 8'h3C, 8'h7F);
		put_vlv(28'd127, 0);     chan_body(8'h8F, 8'h00, 8'hFF);
		put_vlv(28'd128, 0);     chan_body(8'hC5, 8'hFF, 8'h00);
		put_vlv(28'd16383, 0);   chan_body(8'hDA, 8'h00, 8'h00);
		put_vlv(28'd16384, 0);   chan_body(8'hEF, 8'hFF, 8'hFF);
		put_vlv(28'd2097151, 0); chan_body(8'hA3, 8'h55, 8'hAA);
		put_vlv(28'd5, 3);       chan_body(8'hB0, 8'h07, 8'h64);
		// delta cut off after four groups with the continue bit still set
		push_byte(8'h81); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
		chan_body(8'h00, 8'h00, 8'h00);  // status without its top bit: no data bytes
		put_vlv(28'd0, 0);       chan_body(8'h7F, 8'h00, 8'h00);
	endtask

	task automatic test_sysex_events();
		put_vlv(28'd3, 0); sysex_body(8'hF0, 8'd0);
		put_vlv(28'd0, 0); sysex_body(8'hF7, 8'd3);
		put_vlv(28'd1, 0); sysex_body(8'hFE, 8'd1);
	endtask

	task automatic test_meta_events();
		put_vlv(28'd0, 0);  meta_fixed_body(META_SEQ, 40'h12_34_00_00_00);
		put_vlv(28'd2, 0);  meta_fixed_body(META_CHPFX, 40'h0F_00_00_00_00);
		put_vlv(28'd0, 0);  meta_fixed_body(META_TEMPO, 40'h07_A1_20_00_00);
		put_vlv(28'd9, 0);  meta_fixed_body(META_SMPTE, 40'hFF_3B_3B_1D_63);
		put_vlv(28'd0, 0);  meta_fixed_body(META_TSIG, 40'h04_02_18_08_00);
		// key signature: flats (negative), sharps, and the most negative byte
		put_vlv(28'd0, 0);  meta_fixed_body(META_KSIG, 40'hF9_00_00_00_00);
		put_vlv(28'd1, 0);  meta_fixed_body(META_KSIG, 40'h07_01_00_00_00);
		put_vlv(28'd0, 0);  meta_fixed_body(META_KSIG, 40'h80_01_00_00_00);
		// length-prefixed metas: empty, padded length, two-group length
		put_vlv(28'd0, 0);  meta_text_body(8'h03, 28'd0, 0);
		put_vlv(28'd4, 0);  meta_text_body(8'h01, 28'd5, 2);
		put_vlv(28'd0, 0);  meta_text_body(8'h05, 28'd200, 0);
		// unknown type, length cut off after four groups
		put_vlv(28'd0, 0);
		push_byte(ST_META); push_byte(8'h7F);
		push_byte(8'h80); push_byte(8'h80); push_byte(8'h80); push_byte(8'h82);
		push_byte(8'hA5); push_byte(8'h5A);
	endtask

	// Random well-formed events with random content, some noise bursts,
	// a back-to-back stretch and one full drain with a register write.
	task automatic test_random_events();
		int          start;
		int          pick;
		bit          drained;
		logic [27:0] dt;
		logic [7:0]  st;
		logic [7:0]  ty;
		logic [7:0]  len;
		start = bytes_sent;
		drained = 1'b0;
		while (bytes_sent - start < 200) begin
			idle_pct = (bytes_sent - start >= 40 && bytes_sent - start < 140) ? 0 : IDLE_PCT;
			if (!drained && bytes_sent - start >= 150) begin
				drained = 1'b1;
				settle(4);
				write_target(16'($urandom_range(1, 65534)));  // no effect once parsing
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: dt = 28'($urandom_range(0, 127));
				6, 7:             dt = 28'($urandom_range(128, 16383));
				8:                dt = 28'($urandom_range(16384, 2097151));
				default:          dt = 28'($urandom_range(2097152, 4194303));
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 95) put_vlv(dt, $urandom_range(0, 4));
			if (pick < 45) begin
				if ($urandom_range(0, 9) == 0) st = 8'($urandom_range(8'h00, 8'h7F));
				else st = 8'($urandom_range(8'h80, 8'hEF));
				chan_body(st, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end else if (pick < 60) begin
				len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(9, 255))
					: 8'($urandom_range(0, 8));
				sysex_body(8'($urandom_range(8'hF0, 8'hFE)), len);
			end else if (pick < 85) begin
				case ($urandom_range(0, 5))
					0:       ty = META_SEQ;
					1:       ty = META_CHPFX;
					2:       ty = META_TEMPO;
					3:       ty = META_SMPTE;
					4:       ty = META_TSIG;
					default: ty = META_KSIG;
				endcase
				meta_fixed_body(ty, {$urandom, 8'($urandom)});
			end else if (pick < 95) begin
				ty = 8'($urandom_range(0, 255));
				if (fixed_count(ty) >= 0) ty = 8'h01;
				meta_text_body(ty, 28'($urandom_range(0, 6)), $urandom_range(0, 4));
			end else begin
				// noise: no meta status, so nothing can halt or open a long skip
				repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 254)));
				// low bytes bring the parser back to the start of a delta
				while (ph != P_DELTA || acc_bytes != 0) push_byte(8'($urandom_range(0, 127)));
			end
		end
		idle_pct = IDLE_PCT;
	endtask

	// Max deltas until the absolute time pins at all ones, end of track,
	// then bytes that must be swallowed without a result.
	task automatic test_time_saturation_and_end();
		for (int i = 0; i < 18; i++) begin
			put_vlv(28'hFFFFFFF, 0);
			chan_body(8'h90 | 8'(i), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
		push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
		chan_body(8'hC9, 8'h10, 8'h00);
		put_vlv(28'd5, 0);
		push_byte(ST_META);
		push_byte(META_EOT);
		push_byte(8'h00);
		repeat (8) push_byte(8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_track_select();
		test_channel_events();
		test_sysex_events();
		test_meta_events();
		test_random_events();
		test_time_saturation_and_end();
		settle(10);
		if (mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	// watchdog against a hung run
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

/* midi_track_event_parser_top.f */
hw/rtl/mtep_pkg.sv
hw/rtl/mtep_time.sv
hw/rtl/midi_track_event_parser_top.sv
test/tb_midi_track_event_parser_top.sv
